[sv/shgd_pkg.sv]
// ----------------------------------------------------------------------------
// shgd_pkg
// Shared types, constants and helpers of the smoothed hand grab gesture
// detector.
// ----------------------------------------------------------------------------
package shgd_pkg;

   localparam int WINDOW_DEFAULT = 8;
   localparam int NCOORD = 6;
   localparam int COORD_W = 16;
   localparam int RING_W = NCOORD * COORD_W;
   localparam int FMS_W = 10;
   localparam int OPEN_W = 17;
   localparam logic [OPEN_W-1:0] OPEN_MAX = 17'd131071;

   localparam int CSR_DATA_W = 16;
   localparam int THR_W = 15;
   localparam int REL_MS_W = 16;

   localparam logic ENABLE_RESET = 1'b1;
   localparam logic [THR_W-1:0] SWAP_THR_RESET = 15'd819;
   localparam logic [THR_W-1:0] DEADZONE_RESET = 15'd82;
   localparam logic [REL_MS_W-1:0] RELEASE_RESET = 16'd100;

   typedef enum logic [1:0] {
      CSR_GESTURE_ENABLE = 2'd0,
      CSR_SWAP_THRESHOLD = 2'd1,
      CSR_PAN_DEADZONE   = 2'd2,
      CSR_RELEASE_MS     = 2'd3
   } csr_addr_type;

   typedef enum logic [1:0] {
      GESTURE_NONE = 2'd0,
      GESTURE_PAN  = 2'd1,
      GESTURE_SWAP = 2'd2
   } gesture_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_DIVIDE,
      ST_OFFSET,
      ST_GESTURE
   } state_type;

   function automatic logic signed [COORD_W-1:0] sat16(input logic signed [17:0] v);
      logic signed [COORD_W-1:0] r;
      if (v > 18'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -18'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

endpackage

[sv/shgd_if.sv]
// ----------------------------------------------------------------------------
// shgd interfaces
// Valid/ready channels for body frames, results and register writes.
// ----------------------------------------------------------------------------
interface shgd_req_if;
   logic                 valid;
   logic                 ready;
   logic signed [15:0]   hand_x;
   logic signed [15:0]   hand_y;
   logic signed [15:0]   hand_z;
   logic signed [15:0]   spine_x;
   logic signed [15:0]   spine_y;
   logic signed [15:0]   spine_z;
   logic                 right_closed;
   logic                 left_closed;
   logic [shgd_pkg::FMS_W-1:0] frame_ms;

   modport source (output valid, hand_x, hand_y, hand_z, spine_x, spine_y, spine_z,
                   right_closed, left_closed, frame_ms, input ready);
   modport sink (input valid, hand_x, hand_y, hand_z, spine_x, spine_y, spine_z,
                 right_closed, left_closed, frame_ms, output ready);
endinterface

interface shgd_rsp_if;
   logic                 valid;
   logic                 ready;
   logic signed [15:0]   rel_x;
   logic signed [15:0]   rel_y;
   logic signed [15:0]   rel_z;
   logic                 event_valid;
   logic [1:0]           event_kind;
   logic signed [15:0]   delta_x;
   logic signed [15:0]   delta_y;
   logic                 event_flag;
   logic [1:0]           gesture_now;

   modport source (output valid, rel_x, rel_y, rel_z, event_valid, event_kind, delta_x,
                   delta_y, event_flag, gesture_now, input ready);
   modport sink (input valid, rel_x, rel_y, rel_z, event_valid, event_kind, delta_x,
                 delta_y, event_flag, gesture_now, output ready);
endinterface

interface shgd_csr_if;
   logic                              valid;
   logic                              ready;
   shgd_pkg::csr_addr_type            addr;
   logic [shgd_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, addr, data, input ready);
   modport sink (input valid, addr, data, output ready);
endinterface

[sv/shgd_ram.sv]
// ----------------------------------------------------------------------------
// shgd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module shgd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/smoothed_hand_grab_gesture_detector_top.sv]
// ----------------------------------------------------------------------------
// smoothed_hand_grab_gesture_detector_top
// Moving-average joint smoothing and grab gesture rule for body frames.
// ----------------------------------------------------------------------------
// A new item is taken only once the last one is through: the block accepts it
// and reads the oldest sample from the ring RAM, updates the running sums and
// writes the new sample, passes through the shared reciprocal multiplier that
// rounds the six averages one after another, forms the hand minus spine
// offset and applies the gesture rule, which loads the result register and
// waits there only while the previous result has not been taken. Register
// writes are taken in every cycle.
module smoothed_hand_grab_gesture_detector_top #(
   parameter int WINDOW = shgd_pkg::WINDOW_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   shgd_req_if.sink    req_bus,
   shgd_rsp_if.source  rsp_bus,
   shgd_csr_if.sink    csr_bus
);

   localparam int K = $clog2(WINDOW);
   localparam int SUM_W = shgd_pkg::COORD_W + K;
   localparam int S = SUM_W + K;
   localparam int R_W = S + 1;
   localparam int P_W = SUM_W + R_W;
   localparam int Q_W = 17;
   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam int WP_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam logic [2:0] DIV_LAST = 3'(shgd_pkg::NCOORD);

   shgd_pkg::state_type state_ff, state_in;

   logic                            en_ff;
   logic [shgd_pkg::THR_W-1:0]      thr_ff;
   logic [shgd_pkg::THR_W-1:0]      dz_ff;
   logic [shgd_pkg::REL_MS_W-1:0]   rel_ms_ff;

   logic signed [15:0]              smp_ff [shgd_pkg::NCOORD];
   logic                            rc_ff;
   logic                            lc_ff;
   logic [shgd_pkg::FMS_W-1:0]      fms_ff;

   logic signed [SUM_W-1:0]         sum_ff [shgd_pkg::NCOORD];
   logic [CNT_W-1:0]                fill_ff;
   logic [WP_W-1:0]                 wp_ff;
   logic [2:0]                      div_idx_ff;
   logic [P_W-1:0]                  prod_ff;
   logic                            neg_ff;
   logic signed [Q_W-1:0]           avg_ff [shgd_pkg::NCOORD];
   logic signed [15:0]              rel_ff [3];

   logic signed [15:0]              anchor_x_ff;
   logic signed [15:0]              anchor_y_ff;
   logic                            held_ff;
   logic                            latch_ff;
   shgd_pkg::gesture_type           gesture_ff;
   logic [shgd_pkg::OPEN_W-1:0]     open_ff;

   logic                            rsp_valid_ff;
   logic signed [15:0]              out_rel_ff [3];
   logic                            out_ev_valid_ff;
   shgd_pkg::gesture_type           out_ev_kind_ff;
   logic signed [15:0]              out_dx_ff;
   logic signed [15:0]              out_dy_ff;
   logic                            out_flag_ff;
   shgd_pkg::gesture_type           out_gesture_ff;

   logic                            req_ready;
   logic                            ram_rd_en;
   logic                            ram_wr_en;
   logic                            out_load;
   logic [shgd_pkg::RING_W-1:0]     ram_wr_data;
   logic [shgd_pkg::RING_W-1:0]     ram_rd_data;
   logic                            full;

   logic [R_W-1:0]                  recip_tab [WINDOW+1];

   // Reciprocals ceil(2^S / n) give an exact floor quotient for every
   // dividend below 2^SUM_W.
   assign recip_tab[0] = '0;
   for (genvar g = 1; g <= WINDOW; g++) begin : g_recip
      localparam logic [R_W-1:0] RECIP =
         R_W'(((64'd1 << S) + 64'(g) - 64'd1) / 64'(g));
      assign recip_tab[g] = RECIP;
   end

   shgd_ram #(
      .WIDTH (shgd_pkg::RING_W),
      .DEPTH (WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wp_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (wp_ff),
      .rd_data (ram_rd_data)
   );

   assign full = (fill_ff == CNT_W'(WINDOW));
   assign ram_wr_data = {smp_ff[5], smp_ff[4], smp_ff[3], smp_ff[2], smp_ff[1], smp_ff[0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= shgd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      req_ready = 1'b0;
      ram_rd_en = 1'b0;
      ram_wr_en = 1'b0;
      out_load = 1'b0;
      unique case (state_ff)
         shgd_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_bus.valid) begin
               ram_rd_en = 1'b1;
               state_in = shgd_pkg::ST_READ;
            end
         end
         shgd_pkg::ST_READ: begin
            ram_wr_en = 1'b1;
            state_in = shgd_pkg::ST_DIVIDE;
         end
         shgd_pkg::ST_DIVIDE: begin
            if (div_idx_ff == DIV_LAST) begin
               state_in = shgd_pkg::ST_OFFSET;
            end
         end
         shgd_pkg::ST_OFFSET: begin
            state_in = shgd_pkg::ST_GESTURE;
         end
         shgd_pkg::ST_GESTURE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               out_load = 1'b1;
               state_in = shgd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = shgd_pkg::ST_IDLE;
         end
      endcase
   end

   assign req_bus.ready = req_ready;
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff <= shgd_pkg::ENABLE_RESET;
         thr_ff <= shgd_pkg::SWAP_THR_RESET;
         dz_ff <= shgd_pkg::DEADZONE_RESET;
         rel_ms_ff <= shgd_pkg::RELEASE_RESET;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.addr)
            shgd_pkg::CSR_GESTURE_ENABLE: en_ff <= csr_bus.data[0];
            shgd_pkg::CSR_SWAP_THRESHOLD: thr_ff <= csr_bus.data[shgd_pkg::THR_W-1:0];
            shgd_pkg::CSR_PAN_DEADZONE:   dz_ff <= csr_bus.data[shgd_pkg::THR_W-1:0];
            shgd_pkg::CSR_RELEASE_MS:     rel_ms_ff <= csr_bus.data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_bus.valid) begin
         smp_ff[0] <= req_bus.hand_x;
         smp_ff[1] <= req_bus.hand_y;
         smp_ff[2] <= req_bus.hand_z;
         smp_ff[3] <= req_bus.spine_x;
         smp_ff[4] <= req_bus.spine_y;
         smp_ff[5] <= req_bus.spine_z;
         rc_ff <= req_bus.right_closed;
         lc_ff <= req_bus.left_closed;
         fms_ff <= req_bus.frame_ms;
      end
   end

   // Running sums, fill count and ring pointer.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < shgd_pkg::NCOORD; i++) begin
            sum_ff[i] <= '0;
         end
         fill_ff <= '0;
         wp_ff <= '0;
      end else if (ram_wr_en) begin
         for (int i = 0; i < shgd_pkg::NCOORD; i++) begin
            sum_ff[i] <= sum_ff[i] + SUM_W'(smp_ff[i])
               - (full ? SUM_W'(signed'(ram_rd_data[16*i +: 16])) : SUM_W'(0));
         end
         if (!full) begin
            fill_ff <= fill_ff + CNT_W'(1);
         end
         wp_ff <= (wp_ff == WP_W'(WINDOW - 1)) ? '0 : wp_ff + WP_W'(1);
      end
   end

   // Shared rounding divider: one coordinate enters the multiplier per cycle
   // and its quotient is signed and stored in the next.
   logic [2:0]              div_sel;
   logic signed [SUM_W-1:0] div_sum;
   logic [SUM_W-1:0]        div_mag;
   logic [SUM_W-1:0]        div_x;
   logic [Q_W-1:0]          div_q;

   always_comb begin
      div_sel = (div_idx_ff == DIV_LAST) ? 3'd0 : div_idx_ff;
      div_sum = sum_ff[div_sel];
      div_mag = div_sum[SUM_W-1] ? SUM_W'(-div_sum) : SUM_W'(div_sum);
      div_x = div_mag + SUM_W'(fill_ff >> 1);
      div_q = prod_ff[S +: Q_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_idx_ff <= '0;
      end else if (ram_wr_en) begin
         div_idx_ff <= '0;
      end else if (state_ff == shgd_pkg::ST_DIVIDE) begin
         div_idx_ff <= div_idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == shgd_pkg::ST_DIVIDE) begin
         prod_ff <= P_W'(div_x) * P_W'(recip_tab[fill_ff]);
         neg_ff <= div_sum[SUM_W-1];
         if (div_idx_ff != 3'd0) begin
            avg_ff[div_idx_ff - 3'd1] <= neg_ff ? signed'(-div_q) : signed'(div_q);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == shgd_pkg::ST_OFFSET) begin
         for (int i = 0; i < 3; i++) begin
            rel_ff[i] <= shgd_pkg::sat16(18'(avg_ff[i]) - 18'(avg_ff[i+3]));
         end
      end
   end

   // Gesture rule.
   logic [17:0]                  open_sum;
   logic [shgd_pkg::OPEN_W-1:0]  open_new;
   logic [shgd_pkg::OPEN_W-1:0]  open_in;
   logic signed [16:0]           rx;
   logic signed [16:0]           ry;
   logic [16:0]                  rx_mag;
   logic [16:0]                  ry_mag;
   logic signed [15:0]           anchor_x_in;
   logic signed [15:0]           anchor_y_in;
   logic                         held_in;
   logic                         latch_in;
   shgd_pkg::gesture_type        gesture_in;
   logic                         ev_valid;
   shgd_pkg::gesture_type        ev_kind;
   logic signed [15:0]           ev_dx;
   logic signed [15:0]           ev_dy;
   logic                         ev_flag;

   always_comb begin
      open_sum = 18'(open_ff) + 18'(fms_ff);
      open_new = (open_sum > 18'(shgd_pkg::OPEN_MAX)) ? shgd_pkg::OPEN_MAX
                                                      : open_sum[shgd_pkg::OPEN_W-1:0];
      rx = 17'(anchor_x_ff) - 17'(rel_ff[0]);
      ry = 17'(anchor_y_ff) - 17'(rel_ff[1]);
      rx_mag = rx[16] ? 17'(-rx) : 17'(rx);
      ry_mag = ry[16] ? 17'(-ry) : 17'(ry);
      open_in = open_new;
      anchor_x_in = anchor_x_ff;
      anchor_y_in = anchor_y_ff;
      held_in = held_ff;
      latch_in = latch_ff;
      gesture_in = gesture_ff;
      ev_valid = 1'b0;
      ev_kind = shgd_pkg::GESTURE_NONE;
      ev_dx = '0;
      ev_dy = '0;
      ev_flag = 1'b0;
      if (en_ff) begin
         if (rc_ff) begin
            open_in = '0;
            if (held_ff) begin
               if (rx_mag > 17'(thr_ff) && lc_ff) begin
                  gesture_in = shgd_pkg::GESTURE_SWAP;
                  ev_valid = 1'b1;
                  ev_kind = shgd_pkg::GESTURE_SWAP;
                  ev_dx = shgd_pkg::sat16(18'(rx));
                  ev_dy = shgd_pkg::sat16(18'(ry));
                  ev_flag = latch_ff;
                  latch_in = 1'b1;
               end else if (!lc_ff) begin
                  gesture_in = shgd_pkg::GESTURE_PAN;
                  ev_valid = 1'b1;
                  ev_kind = shgd_pkg::GESTURE_PAN;
                  ev_dx = (rx_mag > 17'(dz_ff)) ? shgd_pkg::sat16(18'(rx)) : 16'sd0;
                  ev_dy = (ry_mag > 17'(dz_ff)) ? shgd_pkg::sat16(18'(ry)) : 16'sd0;
                  ev_flag = 1'b1;
               end else begin
                  latch_in = 1'b0;
               end
            end else begin
               gesture_in = shgd_pkg::GESTURE_PAN;
               anchor_x_in = rel_ff[0];
               anchor_y_in = rel_ff[1];
            end
            held_in = 1'b1;
         end else if (open_new > 17'(rel_ms_ff)) begin
            open_in = '0;
            gesture_in = shgd_pkg::GESTURE_NONE;
            anchor_x_in = '0;
            anchor_y_in = '0;
            held_in = 1'b0;
            latch_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         anchor_x_ff <= '0;
         anchor_y_ff <= '0;
         held_ff <= 1'b0;
         latch_ff <= 1'b0;
         gesture_ff <= shgd_pkg::GESTURE_NONE;
         open_ff <= '0;
      end else if (out_load) begin
         anchor_x_ff <= anchor_x_in;
         anchor_y_ff <= anchor_y_in;
         held_ff <= held_in;
         latch_ff <= latch_in;
         gesture_ff <= gesture_in;
         open_ff <= open_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         for (int i = 0; i < 3; i++) begin
            out_rel_ff[i] <= rel_ff[i];
         end
         out_ev_valid_ff <= ev_valid;
         out_ev_kind_ff <= ev_kind;
         out_dx_ff <= ev_dx;
         out_dy_ff <= ev_dy;
         out_flag_ff <= ev_flag;
         out_gesture_ff <= gesture_in;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.rel_x = out_rel_ff[0];
   assign rsp_bus.rel_y = out_rel_ff[1];
   assign rsp_bus.rel_z = out_rel_ff[2];
   assign rsp_bus.event_valid = out_ev_valid_ff;
   assign rsp_bus.event_kind = out_ev_kind_ff;
   assign rsp_bus.delta_x = out_dx_ff;
   assign rsp_bus.delta_y = out_dy_ff;
   assign rsp_bus.event_flag = out_flag_ff;
   assign rsp_bus.gesture_now = out_gesture_ff;

endmodule
